FILE: rtl/adftcs_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// adftcs_pkg: shared types and constants
// Field widths, register indexes, reset values and the configuration bundle
// of the advection-diffusion FTCS stencil.
// -----------------------------------------------------------------------------
package adftcs_pkg;

	localparam int DATA_W     = 32;   // Q8.24 sample and position width
	localparam int GAIN_W     = 32;   // Q0.32 gain width
	localparam int POS_STEP_W = 31;   // grid spacing width
	localparam int GRID_W     = 13;   // point count register width
	localparam int CFG_IDX_W  = 3;    // configuration register index width
	localparam int MUL_W      = 33;   // operand width of the shared multiplier
	localparam int PROD_W     = 2 * MUL_W;

	localparam int MAX_POINTS_DEF   = 4096;
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int MIN_POINTS       = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADVECTION_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_POINTS    = 3'd4;

	localparam logic [GAIN_W-1:0]     DIFFUSION_GAIN_RST = 32'd429496730;
	localparam logic [GAIN_W-1:0]     ADVECTION_GAIN_RST = 32'd10737418;
	localparam logic [DATA_W-1:0]     POSITION_START_RST = 32'hFB00_0000;
	localparam logic [POS_STEP_W-1:0] POSITION_STEP_RST  = 31'd167772;
	localparam logic [GRID_W-1:0]     GRID_POINTS_RST    = 13'd1000;

	typedef struct packed {
		logic [GAIN_W-1:0]     diffusion_gain;
		logic [GAIN_W-1:0]     advection_gain;
		logic [DATA_W-1:0]     position_start;
		logic [POS_STEP_W-1:0] position_step;
		logic [GRID_W-1:0]     grid_points;
	} cfg_t;

endpackage : adftcs_pkg
`default_nettype wire

FILE: rtl/adftcs_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// adftcs_if: channel interfaces
// Valid/ready channels for density samples, advanced results and register
// writes of the advection-diffusion stencil.
// -----------------------------------------------------------------------------
interface adftcs_in_if import adftcs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] density;

	modport source (output valid, output density, input ready);
	modport sink   (input valid, input density, output ready);
endinterface : adftcs_in_if

interface adftcs_out_if import adftcs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] new_density;
	logic                     row_end;

	modport source (output valid, output new_density, output row_end, input ready);
	modport sink   (input valid, input new_density, input row_end, output ready);
endinterface : adftcs_out_if

interface adftcs_cfg_if import adftcs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface : adftcs_cfg_if
`default_nettype wire

FILE: rtl/adftcs_regs.sv
`default_nettype none
// -----------------------------------------------------------------------------
// adftcs_regs: configuration register file
// Decodes register writes and holds the gains, grid geometry and point count.
// -----------------------------------------------------------------------------
module adftcs_regs import adftcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	adftcs_cfg_if.sink  cfg,
	output cfg_t        regs
);

	cfg_t regs_q;

	// Writes are always taken; an unknown index is dropped.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.diffusion_gain <= DIFFUSION_GAIN_RST;
			regs_q.advection_gain <= ADVECTION_GAIN_RST;
			regs_q.position_start <= POSITION_START_RST;
			regs_q.position_step  <= POSITION_STEP_RST;
			regs_q.grid_points    <= GRID_POINTS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DIFFUSION_GAIN: regs_q.diffusion_gain <= cfg.data;
				REG_ADVECTION_GAIN: regs_q.advection_gain <= cfg.data;
				REG_POSITION_START: regs_q.position_start <= cfg.data;
				REG_POSITION_STEP:  regs_q.position_step  <= cfg.data[POS_STEP_W-1:0];
				REG_GRID_POINTS:    regs_q.grid_points    <= cfg.data[GRID_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule : adftcs_regs
`default_nettype wire

FILE: rtl/adftcs_mul.sv
`default_nettype none
// -----------------------------------------------------------------------------
// adftcs_mul: shared signed multiplier
// One signed multiplication per cycle with the product registered.
// -----------------------------------------------------------------------------
module adftcs_mul import adftcs_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  op_a,
	input  logic [MUL_W-1:0]  op_b,
	output logic [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'($signed(op_a) * $signed(op_b));
	end

endmodule : adftcs_mul
`default_nettype wire

FILE: rtl/advection_diffusion_ftcs_step.sv
`default_nettype none
// -----------------------------------------------------------------------------
// advection_diffusion_ftcs_step: one explicit time step of 1-D advection-diffusion
// Streams a grid row of Q8.24 densities and returns the advanced row, with the
// two end points forced to zero and saturated interior results.
// -----------------------------------------------------------------------------
// Old densities of one row enter in index order, one per transfer on the
// samples channel, and the advanced row leaves on the results channel lagging
// by one point: sample 0 yields point 0 (always zero), sample 1 yields nothing,
// sample k yields point k-1, and the final sample also yields the last point
// (zero) with row_end set. Each interior point is worked out on a single 33 by
// 33 bit multiplier under a small sequencer: two products form the flux term,
// and each of the two gain products is split into a low and a high partial
// product, six passes in all, run one per step by the sequencer. An interior
// sample therefore occupies the block through acceptance, the compute steps
// and the loading of the output register, the final sample also through
// loading the row_end result. Sample 0 of a row takes acceptance and loading
// its zero result, and sample 1 only acceptance. The samples channel is not ready
// while a sample is in work, and a result waits in the output register if the
// results channel stalls.
// -----------------------------------------------------------------------------
module advection_diffusion_ftcs_step import adftcs_pkg::*; #(
	parameter int MAX_POINTS   = MAX_POINTS_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	adftcs_cfg_if.sink    cfg,
	adftcs_in_if.sink     samples,
	adftcs_out_if.source  results
);

	// Index and point-count widths follow the largest row.
	localparam int IW      = $clog2(MAX_POINTS);
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int LW      = (CNT_W > GRID_W) ? CNT_W : GRID_W;

	// Datapath widths: the split point of a gain multiplicand, the Q0.32 gain
	// fraction, the flux and Laplacian operands, the gain accumulator and the
	// unsaturated sum.
	localparam int SPLIT   = 24;
	localparam int GFRAC   = GAIN_W;
	localparam int OPND_W  = PROD_W - SPLIT;
	localparam int ACC_W   = 74;
	localparam int SUM_W   = 48;
	localparam int SAT_W   = (SAMPLE_WIDTH < DATA_W) ? SAMPLE_WIDTH : DATA_W;

	localparam logic signed [SUM_W-1:0] SAT_HI =
		SUM_W'((longint'(1) <<< (SAT_W - 1)) - longint'(1));
	localparam logic signed [SUM_W-1:0] SAT_LO =
		SUM_W'(-(longint'(1) <<< (SAT_W - 1)));

	// Top-level states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;
	localparam logic [1:0] ST_END  = 2'd3;

	// Sequencer steps; the first six name what the multiplier is fed in that cycle, the last two finish the sums.
	localparam logic [2:0] STP_FLUX_R  = 3'd0;
	localparam logic [2:0] STP_FLUX_L  = 3'd1;
	localparam logic [2:0] STP_LAP_LO  = 3'd2;
	localparam logic [2:0] STP_LAP_HI  = 3'd3;
	localparam logic [2:0] STP_ADV_LO  = 3'd4;
	localparam logic [2:0] STP_ADV_HI  = 3'd5;
	localparam logic [2:0] STP_ADV_ACC = 3'd6;
	localparam logic [2:0] STP_FINISH  = 3'd7;

	cfg_t cfg_r;

	adftcs_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_r)
	);

	// Row state.
	logic [1:0]        state_q;
	logic [2:0]        step_q;
	logic [IW-1:0]     idx_q;
	logic [DATA_W-1:0] centre_q;
	logic [DATA_W-1:0] win0_q;
	logic [DATA_W-1:0] win1_q;

	// Operands captured when a sample is accepted.
	logic [DATA_W-1:0] p_q;
	logic [DATA_W-1:0] left_q;
	logic [DATA_W-1:0] mid_q;
	logic [DATA_W-1:0] xr_q;
	logic [DATA_W-1:0] xl_q;
	logic              last_q;

	// Working registers of the sequencer.
	logic [OPND_W-1:0] lap_q;
	logic [OPND_W-1:0] flux_q;
	logic [ACC_W-1:0]  acc_q;
	logic [SUM_W-1:0]  sum_q;

	// Output register.
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_end_q;

	logic [LW-1:0]     gp_ext;
	logic [LW-1:0]     n_eff;
	logic [LW-1:0]     last_idx;
	logic              is_first;
	logic              is_second;
	logic              is_last;
	logic [DATA_W-1:0] c_now;
	logic              accept;
	logic              out_free;
	logic              out_load;
	logic [DATA_W-1:0] out_data_d;
	logic              out_end_d;
	logic [DATA_W-1:0] sat_val;

	logic [MUL_W-1:0]  op_a;
	logic [MUL_W-1:0]  op_b;
	logic [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]  prod_ext;
	logic [OPND_W-1:0] lap_w;
	logic [SUM_W-1:0]  acc_int;
	logic [SUM_W-1:0]  mid_ext;

	// A point count outside the supported range is clamped; a sample at or
	// past the last index closes the row, which also covers a count lowered
	// in the middle of a row.
	always_comb begin
		gp_ext = LW'(cfg_r.grid_points);
		if (gp_ext < LW'(MIN_POINTS)) begin
			n_eff = LW'(MIN_POINTS);
		end else if (gp_ext > LW'(MAX_POINTS)) begin
			n_eff = LW'(MAX_POINTS);
		end else begin
			n_eff = gp_ext;
		end
		last_idx = n_eff - LW'(1);
	end

	assign is_first  = (idx_q == '0);
	assign is_second = (idx_q == IW'(1));
	assign is_last   = (LW'(idx_q) >= last_idx);

	// The start position is picked up afresh with sample 0 of every row.
	assign c_now = is_first ? cfg_r.position_start : centre_q;

	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;

	// Row bookkeeping and the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= STP_FLUX_R;
			idx_q    <= '0;
			centre_q <= POSITION_START_RST;
			win0_q   <= '0;
			win1_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= STP_FLUX_R;
						if (is_last) begin
							win0_q   <= '0;
							win1_q   <= '0;
							idx_q    <= '0;
							centre_q <= cfg_r.position_start;
						end else begin
							win0_q   <= win1_q;
							win1_q   <= samples.density;
							idx_q    <= idx_q + IW'(1);
							centre_q <= c_now + {1'b0, cfg_r.position_step};
						end
						if (is_first) begin
							state_q <= ST_PUSH;
						end else if (!is_second) begin
							state_q <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					step_q <= step_q + 3'd1;
					if (step_q == STP_FINISH) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= last_q ? ST_END : ST_IDLE;
					end
				end
				ST_END: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand capture. The left neighbour's position sits two steps behind
	// the right one, with positions wrapping as 32-bit two's complement.
	always_ff @(posedge clk) begin
		if (accept) begin
			p_q    <= samples.density;
			left_q <= win0_q;
			mid_q  <= win1_q;
			xr_q   <= c_now;
			xl_q   <= c_now - {cfg_r.position_step, 1'b0};
			last_q <= is_last;
		end
	end

	// Multiplier feed. The flux uses the samples against their positions; each
	// gain product is split into a low partial product on the bottom SPLIT
	// bits of the operand (unsigned) and a high one on the signed remainder.
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (step_q)
			STP_FLUX_R: begin
				op_a = {{(MUL_W - DATA_W){p_q[DATA_W-1]}}, p_q};
				op_b = {{(MUL_W - DATA_W){xr_q[DATA_W-1]}}, xr_q};
			end
			STP_FLUX_L: begin
				op_a = {{(MUL_W - DATA_W){left_q[DATA_W-1]}}, left_q};
				op_b = {{(MUL_W - DATA_W){xl_q[DATA_W-1]}}, xl_q};
			end
			STP_LAP_LO: begin
				op_a = {{(MUL_W - SPLIT){1'b0}}, lap_q[SPLIT-1:0]};
				op_b = {{(MUL_W - GAIN_W){1'b0}}, cfg_r.diffusion_gain};
			end
			STP_LAP_HI: begin
				op_a = {{(MUL_W - OPND_W + SPLIT){lap_q[OPND_W-1]}},
					lap_q[OPND_W-1:SPLIT]};
				op_b = {{(MUL_W - GAIN_W){1'b0}}, cfg_r.diffusion_gain};
			end
			STP_ADV_LO: begin
				op_a = {{(MUL_W - SPLIT){1'b0}}, flux_q[SPLIT-1:0]};
				op_b = {{(MUL_W - GAIN_W){1'b0}}, cfg_r.advection_gain};
			end
			STP_ADV_HI: begin
				op_a = {{(MUL_W - OPND_W + SPLIT){flux_q[OPND_W-1]}},
					flux_q[OPND_W-1:SPLIT]};
				op_b = {{(MUL_W - GAIN_W){1'b0}}, cfg_r.advection_gain};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	adftcs_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	// Second difference p[i+1] - 2p[i] + p[i-1], exact in the operand width.
	assign lap_w =
		{{(OPND_W - DATA_W){p_q[DATA_W-1]}}, p_q}
		- {{(OPND_W - DATA_W - 1){mid_q[DATA_W-1]}}, mid_q, 1'b0}
		+ {{(OPND_W - DATA_W){left_q[DATA_W-1]}}, left_q};

	assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign acc_int  = {{(SUM_W - ACC_W + GFRAC){acc_q[ACC_W-1]}}, acc_q[ACC_W-1:GFRAC]};
	assign mid_ext  = {{(SUM_W - DATA_W){mid_q[DATA_W-1]}}, mid_q};

	// Arithmetic shifts by dropping low bits give the floor on negative values,
	// so each term is rounded toward minus infinity on its own.
	always_ff @(posedge clk) begin
		if (accept && is_first) begin
			sum_q <= '0;
		end else if (state_q == ST_CALC) begin
			case (step_q)
				STP_FLUX_R: lap_q  <= lap_w;
				STP_FLUX_L: flux_q <= prod_q[PROD_W-1:SPLIT];
				STP_LAP_LO: flux_q <= flux_q - prod_q[PROD_W-1:SPLIT];
				STP_LAP_HI: acc_q  <= prod_ext;
				STP_ADV_LO: acc_q  <= acc_q + (prod_ext << SPLIT);
				STP_ADV_HI: begin
					sum_q <= mid_ext + acc_int;
					acc_q <= prod_ext;
				end
				STP_ADV_ACC: acc_q <= acc_q + (prod_ext << SPLIT);
				STP_FINISH:  sum_q <= sum_q + acc_int;
				default: begin
				end
			endcase
		end
	end

	// Saturation to the sample range.
	always_comb begin
		if ($signed(sum_q) > SAT_HI) begin
			sat_val = SAT_HI[DATA_W-1:0];
		end else if ($signed(sum_q) < SAT_LO) begin
			sat_val = SAT_LO[DATA_W-1:0];
		end else begin
			sat_val = sum_q[DATA_W-1:0];
		end
	end

	// The output register takes a new result once the previous one has been
	// transferred or is being transferred in this cycle.
	assign out_free = !out_valid_q || results.ready;

	always_comb begin
		out_load   = 1'b0;
		out_data_d = sat_val;
		out_end_d  = 1'b0;
		case (state_q)
			ST_PUSH: begin
				out_load = out_free;
			end
			ST_END: begin
				out_load   = out_free;
				out_data_d = '0;
				out_end_d  = 1'b1;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_data_d;
			out_end_q  <= out_end_d;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.new_density = out_data_q;
	assign results.row_end     = out_end_q;

endmodule : advection_diffusion_ftcs_step
`default_nettype wire

FILE: bench/tb_advection_diffusion_ftcs_step.sv
// -----------------------------------------------------------------------------
// tb_advection_diffusion_ftcs_step: self-checking bench for the FTCS stencil
// Streams grid rows of Q8.24 densities through the block under several register
// settings and idling patterns. Every advanced point that comes back is checked
// against an independent fixed-point prediction of the explicit step.
// -----------------------------------------------------------------------------
module tb_advection_diffusion_ftcs_step import adftcs_pkg::*; ();

	// Saturation bounds of a result sample.
	localparam longint SAMPLE_MAX = 64'sd2147483647;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	// Indexes above the last listed register must be ignored by the block.
	localparam logic [CFG_IDX_W-1:0] REG_UNLISTED_FIRST = REG_GRID_POINTS + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNLISTED_LAST  = '1;

	// The settle wait comfortably covers the work on a sample that yields no result.
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int PHASE_ITEMS   = 140;
	localparam int RANDOM_PHASES = 8;

	// -------------------------------------------------------------------------
	// Scoreboard: keeps a private copy of the registers and of the row state,
	// works out the points each accepted sample releases, and checks results in
	// order against them.
	// -------------------------------------------------------------------------
	class ftcs_row_tracker;
		logic [GAIN_W-1:0]     diffusion_gain;
		logic [GAIN_W-1:0]     advection_gain;
		logic [DATA_W-1:0]     position_start;
		logic [POS_STEP_W-1:0] position_step;
		logic [GRID_W-1:0]     grid_points;

		longint                far_sample;    // sample two points back
		longint                near_sample;   // previous sample
		int unsigned           next_index;
		logic [DATA_W-1:0]     next_position;

		logic [DATA_W-1:0]     pending_density[$];
		bit                    pending_row_end[$];
		int                    mismatches;

		function new();
			diffusion_gain = DIFFUSION_GAIN_RST;
			advection_gain = ADVECTION_GAIN_RST;
			position_start = POSITION_START_RST;
			position_step  = POSITION_STEP_RST;
			grid_points    = GRID_POINTS_RST;
			far_sample     = 0;
			near_sample    = 0;
			next_index     = 0;
			next_position  = POSITION_START_RST;
			mismatches     = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] index, logic [DATA_W-1:0] value);
			case (index)
				REG_DIFFUSION_GAIN: diffusion_gain = value;
				REG_ADVECTION_GAIN: advection_gain = value;
				REG_POSITION_START: position_start = value;
				REG_POSITION_STEP:  position_step  = value[POS_STEP_W-1:0];
				REG_GRID_POINTS:    grid_points    = value[GRID_W-1:0];
				default: ;
			endcase
		endfunction

		// floor(a * g / 2^32) with g an unsigned Q0.32 gain.
		function longint scale_by_gain(longint a, logic [GAIN_W-1:0] g);
			logic signed [96:0] product;
			product = a * $signed({1'b0, g});
			product = product >>> 32;
			return product[63:0];
		endfunction

		function logic [DATA_W-1:0] clip(longint v);
			if (v > SAMPLE_MAX)
				return SAMPLE_MAX[DATA_W-1:0];
			if (v < SAMPLE_MIN)
				return SAMPLE_MIN[DATA_W-1:0];
			return v[DATA_W-1:0];
		endfunction

		function void queue_point(logic [DATA_W-1:0] value, bit row_end);
			pending_density.push_back(value);
			pending_row_end.push_back(row_end);
		endfunction

		function void take_sample(logic signed [DATA_W-1:0] density);
			longint            p;
			longint            x_right;
			longint            x_left;
			longint            lap;
			longint            flux;
			longint            total;
			int unsigned       points;
			logic [DATA_W-1:0] left_position;
			p = density;
			points = grid_points;
			if (points < MIN_POINTS)
				points = MIN_POINTS;
			if (points > MAX_POINTS_DEF)
				points = MAX_POINTS_DEF;

			if (next_index == 0) begin
				// The start position is taken up at the first sample of a row.
				next_position = position_start;
				queue_point('0, 1'b0);
			end else if (next_index >= 2) begin
				left_position = next_position - {position_step, 1'b0};
				x_right = $signed(next_position);
				x_left  = $signed(left_position);
				lap   = p - 2 * near_sample + far_sample;
				flux  = ((p * x_right) >>> 24) - ((far_sample * x_left) >>> 24);
				total = near_sample + scale_by_gain(lap, diffusion_gain)
					+ scale_by_gain(flux, advection_gain);
				queue_point(clip(total), 1'b0);
			end

			if (next_index >= points - 1) begin
				queue_point('0, 1'b1);
				far_sample    = 0;
				near_sample   = 0;
				next_index    = 0;
				next_position = position_start;
			end else begin
				far_sample    = near_sample;
				near_sample   = p;
				next_index++;
				next_position = next_position + position_step;
			end
		endfunction

		function void check_point(logic [DATA_W-1:0] new_density, logic row_end);
			logic [DATA_W-1:0] want_density;
			bit                want_row_end;
			if (pending_density.size() == 0) begin
				$error("unexpected result: new_density %h row_end %b", new_density, row_end);
				mismatches++;
				return;
			end
			want_density = pending_density.pop_front();
			want_row_end = pending_row_end.pop_front();
			if (new_density !== want_density) begin
				$error("new_density: expected %h, actual %h", want_density, new_density);
				mismatches++;
			end
			if (row_end !== want_row_end) begin
				$error("row_end: expected %b, actual %b", want_row_end, row_end);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return pending_density.size();
		endfunction
	endclass

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [DATA_W-1:0]    value;
	} reg_write_t;

	logic clk;
	logic arst_n;

	adftcs_cfg_if cfg_ch ();
	adftcs_in_if  sample_ch ();
	adftcs_out_if result_ch ();

	advection_diffusion_ftcs_step uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.samples (sample_ch),
		.results (result_ch)
	);

	ftcs_row_tracker tracker = new();

	// Work lists drained by the driving tasks, plus the idling knobs of the
	// current phase. The hold-off count is consumed by the receiving process.
	logic signed [DATA_W-1:0] density_burst[$];
	reg_write_t               register_writes[$];
	int                       send_idle_pct;
	int                       stall_pct;
	int                       hold_off_left;
	int                       cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a correct run finishes far inside this budget, so running out
	// of it means the block has hung or lost a transfer.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_advection_diffusion_ftcs_step NOT OK");
		$finish;
	end

	// Result side. Each transfer is checked at the edge on which it happens;
	// ready for the next edge is then drawn at random, or held low while a
	// hold-off is running so that the block backs up into its input.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready)
				tracker.check_point(result_ch.new_density, result_ch.row_end);
			if (hold_off_left > 0) begin
				hold_off_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offers the queued samples in order, with random gaps in front of each.
	// Valid stays high between back-to-back samples and drops once at the end.
	task automatic send_burst();
		logic signed [DATA_W-1:0] density;
		while (density_burst.size() > 0) begin
			density = density_burst.pop_front();
			while ($urandom_range(99) < send_idle_pct) begin
				sample_ch.valid <= 1'b0;
				@(posedge clk);
			end
			sample_ch.valid   <= 1'b1;
			sample_ch.density <= density;
			@(posedge clk);
			while (!sample_ch.ready)
				@(posedge clk);
			tracker.take_sample(density);
		end
		sample_ch.valid <= 1'b0;
	endtask

	// Performs the queued register writes, one transfer each.
	task automatic program_registers();
		reg_write_t w;
		while (register_writes.size() > 0) begin
			w = register_writes.pop_front();
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= w.index;
			cfg_ch.data  <= w.value;
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			tracker.write_register(w.index, w.value);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Waits for every predicted point, then lets a sample that releases no
	// point (the second of a row) finish before registers are touched.
	task automatic settle();
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_write(logic [CFG_IDX_W-1:0] index, logic [DATA_W-1:0] value);
		reg_write_t w;
		w.index = index;
		w.value = value;
		register_writes.push_back(w);
	endtask

	// Mostly modest magnitudes, with rail values and full-range samples mixed
	// in so that both saturated and ordinary interior points occur.
	function automatic logic [DATA_W-1:0] pick_density();
		case ($urandom_range(9))
			0:       return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1:       return ($urandom_range(1)) ? 32'h0000_0000 : 32'hFFFF_FFFF;
			2, 3, 4: return $urandom;
			default: return $signed($urandom) >>> $urandom_range(5, 20);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(5))
			0:       return '0;
			1:       return '1;
			2, 3:    return $urandom;
			default: return $urandom >> $urandom_range(4, 24);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_grid_points();
		logic [DATA_W-1:0] upper;
		upper = $urandom & ~32'(2 ** GRID_W - 1);
		case ($urandom_range(9))
			0, 1:    return upper | 32'($urandom_range(0, 2 ** GRID_W - 1));
			2, 3:    return upper | 32'($urandom_range(13, 64));
			default: return upper | 32'($urandom_range(0, 12));
		endcase
	endfunction

	initial begin
		arst_n            <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= '0;
		cfg_ch.data       <= '0;
		sample_ch.valid   <= 1'b0;
		sample_ch.density <= '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_off_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: the reset settings with rail and sign-boundary samples. The
		// point count is then lowered below the current index in mid row, so
		// the very next sample must close the row.
		density_burst = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
		send_burst();
		settle();
		queue_write(REG_GRID_POINTS, 32'd3);
		program_registers();
		density_burst = '{32'h7FFF_FFFF};
		send_burst();
		settle();

		// Directed: full diffusion, no advection, extreme start and spacing so
		// that positions wrap. A point count of zero behaves as three, the
		// spacing write carries a top bit that must be dropped, and a write to
		// an unlisted index must leave everything alone.
		queue_write(REG_DIFFUSION_GAIN, '1);
		queue_write(REG_ADVECTION_GAIN, '0);
		queue_write(REG_POSITION_START, 32'h8000_0000);
		queue_write(REG_POSITION_STEP, 32'hFFFF_FFFF);
		queue_write(REG_GRID_POINTS, 32'd0);
		queue_write(REG_UNLISTED_LAST, 32'h0000_0001);
		program_registers();
		density_burst = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
		send_burst();
		settle();

		// Directed: pure advection from the top of the position range.
		queue_write(REG_DIFFUSION_GAIN, '0);
		queue_write(REG_ADVECTION_GAIN, '1);
		queue_write(REG_POSITION_START, 32'h7FFF_FFFF);
		queue_write(REG_POSITION_STEP, 32'h0012_3456);
		queue_write(REG_GRID_POINTS, 32'd4);
		program_registers();
		density_burst = '{32'h0100_0000, 32'hFF00_0000, 32'h0200_0000, 32'h0080_0000};
		send_burst();
		settle();

		// Random phases. Each one takes a fresh register setting, then streams
		// samples under its own idling pattern; rows are cut wherever the phase
		// ends, so the next setting often lands in mid row.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 57; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 57; end
				default: begin send_idle_pct = 26; stall_pct = 26; end
			endcase
			queue_write(REG_DIFFUSION_GAIN, pick_gain());
			queue_write(REG_ADVECTION_GAIN, pick_gain());
			queue_write(REG_POSITION_START, $urandom);
			queue_write(REG_POSITION_STEP, $urandom >> $urandom_range(0, 31));
			queue_write(REG_GRID_POINTS, pick_grid_points());
			if ($urandom_range(2) == 0)
				queue_write(CFG_IDX_W'($urandom_range(REG_UNLISTED_FIRST,
					REG_UNLISTED_LAST)), $urandom);
			program_registers();
			for (int i = 0; i < PHASE_ITEMS; i++)
				density_burst.push_back(pick_density());
			// Early on, starve the result side for a long while so that the
			// output register fills and the sample side has to stall.
			if (phase == 0)
				hold_off_left = 400;
			send_burst();
			settle();
		end

		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("tb_advection_diffusion_ftcs_step OK");
		else
			$display("tb_advection_diffusion_ftcs_step NOT OK");
		$finish;
	end

endmodule : tb_advection_diffusion_ftcs_step
